### hdl/lsvm_pkg.sv
// shared types, constants and helpers for the linear svm sgd trainer
package lsvm_pkg;

   localparam int FEATURE_COUNT = 8;
   localparam int FEATURE_WIDTH = 16;
   localparam int WORD_WIDTH = 32;
   localparam int PROD_WIDTH = WORD_WIDTH + FEATURE_WIDTH;
   localparam int SUM_WIDTH = PROD_WIDTH + $clog2(FEATURE_COUNT) + 1;
   localparam int SCORE_WIDE = SUM_WIDTH + 1;
   localparam int CNT_WIDTH = $clog2(FEATURE_COUNT + 1);
   localparam int UPD_WIDTH = WORD_WIDTH + 3;

   localparam int CSR_INDEX_WIDTH = 2;
   localparam int CSR_DATA_WIDTH = 16;

   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_LEARNING_RATE = 2'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_REGULARIZATION = 2'd1;

   localparam logic [CSR_DATA_WIDTH-1:0] LEARNING_RATE_RESET = 16'd655;
   localparam logic [CSR_DATA_WIDTH-1:0] REGULARIZATION_RESET = 16'd6554;

   localparam logic OP_TRAIN = 1'b0;
   localparam logic OP_PREDICT = 1'b1;

   localparam logic signed [WORD_WIDTH-1:0] Q_ONE = 32'sd65536;
   localparam logic signed [WORD_WIDTH-1:0] WORD_MAX = 32'sh7fffffff;
   localparam logic signed [WORD_WIDTH-1:0] WORD_MIN = 32'sh80000000;

   typedef struct packed {
      logic operation;
      logic label_positive;
      logic signed [FEATURE_WIDTH-1:0] feature_0;
      logic signed [FEATURE_WIDTH-1:0] feature_1;
      logic signed [FEATURE_WIDTH-1:0] feature_2;
      logic signed [FEATURE_WIDTH-1:0] feature_3;
      logic signed [FEATURE_WIDTH-1:0] feature_4;
      logic signed [FEATURE_WIDTH-1:0] feature_5;
      logic signed [FEATURE_WIDTH-1:0] feature_6;
      logic signed [FEATURE_WIDTH-1:0] feature_7;
   } req_type;

   typedef struct packed {
      logic class_positive;
      logic signed [WORD_WIDTH-1:0] score;
      logic margin_met;
   } rsp_type;

   typedef struct packed {
      logic load;
      logic update;
      logic add_step;
      logic label_positive;
   } cell_ctrl_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SUM,
      ST_SCORE,
      ST_UPDATE,
      ST_DONE
   } state_type;

   function automatic logic signed [WORD_WIDTH-1:0] sat_word(
      input logic signed [UPD_WIDTH-1:0] v
   );
      logic [UPD_WIDTH-WORD_WIDTH:0] top_bits;
      top_bits = v[UPD_WIDTH-1:WORD_WIDTH-1];
      if ((&top_bits) || (~|top_bits)) begin
         return v[WORD_WIDTH-1:0];
      end else if (v[UPD_WIDTH-1]) begin
         return WORD_MIN;
      end else begin
         return WORD_MAX;
      end
   endfunction

endpackage

### hdl/lsvm_cell.sv
// one weight cell: holds a weight and a feature, passes the partial dot product on
module lsvm_cell (
   input  logic                                       clock,
   input  logic                                       reset,
   input  lsvm_pkg::cell_ctrl_type                    ctrl,
   input  logic signed [lsvm_pkg::FEATURE_WIDTH-1:0]  feature,
   input  logic [lsvm_pkg::WORD_WIDTH-1:0]            decay_rate,
   input  logic [lsvm_pkg::CSR_DATA_WIDTH-1:0]        learning_rate,
   input  logic signed [lsvm_pkg::SUM_WIDTH-1:0]      sum_in,
   output logic signed [lsvm_pkg::SUM_WIDTH-1:0]      sum_out
);

   localparam int W = lsvm_pkg::WORD_WIDTH;
   localparam int FW = lsvm_pkg::FEATURE_WIDTH;
   localparam int PW = lsvm_pkg::PROD_WIDTH;
   localparam int SW = lsvm_pkg::SUM_WIDTH;
   localparam int UW = lsvm_pkg::UPD_WIDTH;
   localparam int HALF = W / 2;
   localparam int DPW = HALF + 1 + W;
   localparam int DSW = 2 * W + 2;
   localparam int LXW = HALF + 1 + FW;
   localparam int STW = LXW + 1 - 8;

   logic signed [W-1:0]   w_ff, w_in;
   logic signed [FW-1:0]  x_ff, x_in;
   logic signed [PW-1:0]  prod_ff, prod_in;
   logic signed [DPW-1:0] dhi_ff, dhi_in, dlo_ff, dlo_in;
   logic signed [W:0]     decay_ff, decay_in;
   logic signed [LXW-1:0] lrx_ff, lrx_in;
   logic signed [STW-1:0] step_ff, step_in;
   logic signed [SW-1:0]  sum_ff, sum_in_next;
   logic signed [DSW-1:0] decay_sum;
   logic signed [LXW:0]   lrx_signed;
   logic signed [UW-1:0]  w_next;

   always_comb begin
      x_in = ctrl.load ? feature : x_ff;
      prod_in = w_ff * x_ff;
      dhi_in = $signed({1'b0, decay_rate[W-1:HALF]}) * w_ff;
      dlo_in = $signed({1'b0, decay_rate[HALF-1:0]}) * w_ff;
      decay_sum = (DSW'(dhi_ff) <<< HALF) + DSW'(dlo_ff);
      decay_in = (W + 1)'(decay_sum >>> W);
      lrx_in = $signed({1'b0, learning_rate}) * x_ff;
      lrx_signed = ctrl.label_positive ? (LXW + 1)'(lrx_ff) : -(LXW + 1)'(lrx_ff);
      step_in = STW'(lrx_signed >>> 8);
      w_next = UW'(w_ff) - UW'(decay_ff) + (ctrl.add_step ? UW'(step_ff) : '0);
      w_in = ctrl.update ? lsvm_pkg::sat_word(w_next) : w_ff;
      sum_in_next = sum_in + SW'(prod_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         w_ff <= '0;
      end else begin
         w_ff <= w_in;
      end
   end

   always_ff @(posedge clock) begin
      x_ff <= x_in;
      prod_ff <= prod_in;
      dhi_ff <= dhi_in;
      dlo_ff <= dlo_in;
      decay_ff <= decay_in;
      lrx_ff <= lrx_in;
      step_ff <= step_in;
      sum_ff <= sum_in_next;
   end

   assign sum_out = sum_ff;

endmodule

### hdl/lsvm_ctrl.sv
// sequencer, config registers, score, bias and result register
module lsvm_ctrl (
   input  logic                                        clock,
   input  logic                                        reset,
   input  logic                                        req_valid,
   output logic                                        req_stall,
   input  logic                                        req_operation,
   input  logic                                        req_label_positive,
   output logic                                        rsp_valid,
   input  logic                                        rsp_stall,
   output lsvm_pkg::rsp_type                           rsp_data,
   input  logic                                        csr_valid,
   output logic                                        csr_ready,
   input  logic [lsvm_pkg::CSR_INDEX_WIDTH-1:0]        csr_index,
   input  logic [lsvm_pkg::CSR_DATA_WIDTH-1:0]         csr_data,
   input  logic signed [lsvm_pkg::SUM_WIDTH-1:0]       sum_last,
   output lsvm_pkg::cell_ctrl_type                     cell_ctrl,
   output logic [lsvm_pkg::WORD_WIDTH-1:0]             decay_rate,
   output logic [lsvm_pkg::CSR_DATA_WIDTH-1:0]         learning_rate
);

   localparam int W = lsvm_pkg::WORD_WIDTH;
   localparam int CW = lsvm_pkg::CNT_WIDTH;
   localparam int DW = lsvm_pkg::CSR_DATA_WIDTH;
   localparam int UW = lsvm_pkg::UPD_WIDTH;
   localparam int SCW = lsvm_pkg::SCORE_WIDE;

   lsvm_pkg::state_type state_ff, state_in;
   logic [CW-1:0]        cnt_ff, cnt_in;
   logic [DW-1:0]        lr_ff, lr_in, reg_ff, reg_in;
   logic [W-1:0]         p_ff, p_in;
   logic                 train_ff, train_in, label_ff, label_in;
   logic signed [W-1:0]  score_ff, score_in, bias_ff, bias_in;
   logic                 met_ff, met_in, met;
   logic                 rsp_valid_ff, rsp_valid_in;
   lsvm_pkg::rsp_type    rsp_ff, rsp_in;
   logic                 load, update, rsp_load;
   logic signed [SCW-1:0] score_wide;
   logic [SCW-W:0]        score_top;
   logic signed [UW-1:0]  bias_next;
   logic signed [UW-1:0]  lr_ext;

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         lsvm_pkg::ST_IDLE: begin
            if (req_valid) begin
               state_in = lsvm_pkg::ST_SUM;
            end
         end
         lsvm_pkg::ST_SUM: begin
            if (cnt_ff == CW'(lsvm_pkg::FEATURE_COUNT)) begin
               state_in = lsvm_pkg::ST_SCORE;
            end
         end
         lsvm_pkg::ST_SCORE: state_in = lsvm_pkg::ST_UPDATE;
         lsvm_pkg::ST_UPDATE: state_in = lsvm_pkg::ST_DONE;
         lsvm_pkg::ST_DONE: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               state_in = lsvm_pkg::ST_IDLE;
            end
         end
         default: state_in = lsvm_pkg::ST_IDLE;
      endcase
   end

   // state outputs
   always_comb begin
      req_stall = 1'b1;
      load = 1'b0;
      update = 1'b0;
      rsp_load = 1'b0;
      case (state_ff)
         lsvm_pkg::ST_IDLE: begin
            req_stall = 1'b0;
            load = req_valid;
         end
         lsvm_pkg::ST_SUM: ;
         lsvm_pkg::ST_SCORE: ;
         lsvm_pkg::ST_UPDATE: update = train_ff;
         lsvm_pkg::ST_DONE: rsp_load = !rsp_valid_ff || !rsp_stall;
         default: ;
      endcase
   end

   always_comb begin
      cnt_in = (state_ff == lsvm_pkg::ST_SUM) ? cnt_ff + CW'(1) : '0;

      lr_in = lr_ff;
      reg_in = reg_ff;
      if (csr_valid) begin
         case (csr_index)
            lsvm_pkg::CSR_LEARNING_RATE: lr_in = csr_data;
            lsvm_pkg::CSR_REGULARIZATION: reg_in = csr_data;
            default: ;
         endcase
      end
      p_in = lr_ff * reg_ff;

      train_in = load ? (req_operation == lsvm_pkg::OP_TRAIN) : train_ff;
      label_in = load ? req_label_positive : label_ff;

      // floor shift of the dot product, add bias, clamp
      score_wide = SCW'(sum_last >>> 8) + SCW'(bias_ff);
      score_top = score_wide[SCW-1:W-1];
      if ((&score_top) || (~|score_top)) begin
         score_in = score_wide[W-1:0];
      end else if (score_wide[SCW-1]) begin
         score_in = lsvm_pkg::WORD_MIN;
      end else begin
         score_in = lsvm_pkg::WORD_MAX;
      end
      // score is kept from the weights and bias before the update
      if (state_ff != lsvm_pkg::ST_SCORE) begin
         score_in = score_ff;
      end

      met = train_ff && (label_ff ? (score_ff >= lsvm_pkg::Q_ONE)
                                  : (score_ff <= -lsvm_pkg::Q_ONE));
      met_in = (state_ff == lsvm_pkg::ST_UPDATE) ? met : met_ff;

      lr_ext = $signed({{(UW - DW){1'b0}}, lr_ff});
      bias_next = UW'(bias_ff) + (label_ff ? lr_ext : -lr_ext);
      bias_in = (update && !met) ? lsvm_pkg::sat_word(bias_next) : bias_ff;

      rsp_in = rsp_ff;
      if (rsp_load) begin
         rsp_in.class_positive = !score_ff[W-1];
         rsp_in.score = score_ff;
         rsp_in.margin_met = met_ff;
      end
      rsp_valid_in = rsp_load || (rsp_valid_ff && rsp_stall);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= lsvm_pkg::ST_IDLE;
         cnt_ff <= '0;
         lr_ff <= lsvm_pkg::LEARNING_RATE_RESET;
         reg_ff <= lsvm_pkg::REGULARIZATION_RESET;
         bias_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         cnt_ff <= cnt_in;
         lr_ff <= lr_in;
         reg_ff <= reg_in;
         bias_ff <= bias_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      p_ff <= p_in;
      train_ff <= train_in;
      label_ff <= label_in;
      score_ff <= score_in;
      met_ff <= met_in;
      rsp_ff <= rsp_in;
   end

   always_comb begin
      cell_ctrl.load = load;
      cell_ctrl.update = update;
      cell_ctrl.add_step = !met;
      cell_ctrl.label_positive = label_ff;
   end

   assign csr_ready = 1'b1;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data = rsp_ff;
   assign decay_rate = p_ff;
   assign learning_rate = lr_ff;

endmodule

### hdl/linear_svm_sgd_trainer.sv
// top level: linear svm hinge loss sgd trainer and predictor
//
//  channel  direction  handshake        payload
//  req      in         valid / stall    req_type: operation, label, features
//  rsp      out        valid / stall    rsp_type: class, score, margin flag
//  csr      in         valid / ready    index and 16-bit data
//
// an item runs through the sum, score, update and done states before the next is
// taken; during the sum state the partial sum travels one cell per cycle
// reset loads the rate registers with their defaults and zeroes weights and bias
// a stalled result sits in the output register; the next item is taken meanwhile
// and waits only at its own result
module linear_svm_sgd_trainer (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_valid,
   output logic                                   req_stall,
   input  lsvm_pkg::req_type                      req_data,
   output logic                                   rsp_valid,
   input  logic                                   rsp_stall,
   output lsvm_pkg::rsp_type                      rsp_data,
   input  logic                                   csr_valid,
   output logic                                   csr_ready,
   input  logic [lsvm_pkg::CSR_INDEX_WIDTH-1:0]   csr_index,
   input  logic [lsvm_pkg::CSR_DATA_WIDTH-1:0]    csr_data
);

   localparam int N = lsvm_pkg::FEATURE_COUNT;
   localparam int SW = lsvm_pkg::SUM_WIDTH;

   logic signed [lsvm_pkg::FEATURE_WIDTH-1:0] features [N];
   logic signed [SW-1:0]                      sum_chain [N+1];
   lsvm_pkg::cell_ctrl_type                   cell_ctrl;
   logic [lsvm_pkg::WORD_WIDTH-1:0]           decay_rate;
   logic [lsvm_pkg::CSR_DATA_WIDTH-1:0]       learning_rate;

   always_comb begin
      features[0] = req_data.feature_0;
      features[1] = req_data.feature_1;
      features[2] = req_data.feature_2;
      features[3] = req_data.feature_3;
      features[4] = req_data.feature_4;
      features[5] = req_data.feature_5;
      features[6] = req_data.feature_6;
      features[7] = req_data.feature_7;
   end

   assign sum_chain[0] = '0;

   for (genvar i = 0; i < N; i++) begin : g_cell
      lsvm_cell u_cell (
         .clock         (clock),
         .reset         (reset),
         .ctrl          (cell_ctrl),
         .feature       (features[i]),
         .decay_rate    (decay_rate),
         .learning_rate (learning_rate),
         .sum_in        (sum_chain[i]),
         .sum_out       (sum_chain[i+1])
      );
   end

   lsvm_ctrl u_ctrl (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_operation      (req_data.operation),
      .req_label_positive (req_data.label_positive),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_data           (rsp_data),
      .csr_valid          (csr_valid),
      .csr_ready          (csr_ready),
      .csr_index          (csr_index),
      .csr_data           (csr_data),
      .sum_last           (sum_chain[N]),
      .cell_ctrl          (cell_ctrl),
      .decay_rate         (decay_rate),
      .learning_rate      (learning_rate)
   );

endmodule

### bench/svm_result_checker.sv
`timescale 1ns / 100ps
// checker for the svm trainer: predicts each score and weight update, compares every result
module svm_result_checker (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   input  logic                                 req_stall,
   input  lsvm_pkg::req_type                    req_data,
   input  logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   input  lsvm_pkg::rsp_type                    rsp_data,
   input  logic                                 csr_valid,
   input  logic                                 csr_ready,
   input  logic [lsvm_pkg::CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [lsvm_pkg::CSR_DATA_WIDTH-1:0]  csr_data,
   output int                                   mismatch_count,
   output int                                   pending_count
);
   import lsvm_pkg::*;

   localparam longint WORD_TOP = 64'sd2147483647;
   localparam longint WORD_BOTTOM = -64'sd2147483648;

   logic signed [WORD_WIDTH-1:0] weights [FEATURE_COUNT];
   logic signed [WORD_WIDTH-1:0] bias;
   logic [CSR_DATA_WIDTH-1:0] rate;
   logic [CSR_DATA_WIDTH-1:0] decay_strength;
   rsp_type score_queue [$];
   rsp_type predicted;
   int errors = 0;

   function automatic longint clamp_word(input longint v);
      if (v > WORD_TOP) begin
         return WORD_TOP;
      end
      if (v < WORD_BOTTOM) begin
         return WORD_BOTTOM;
      end
      return v;
   endfunction

   task automatic score_and_update(input req_type item, output rsp_type result);
      longint feat [FEATURE_COUNT];
      longint acc;
      longint score;
      longint y;
      longint lr;
      longint decay_rate;
      longint w;
      longint nw;
      logic met;
      feat[0] = longint'($signed(item.feature_0));
      feat[1] = longint'($signed(item.feature_1));
      feat[2] = longint'($signed(item.feature_2));
      feat[3] = longint'($signed(item.feature_3));
      feat[4] = longint'($signed(item.feature_4));
      feat[5] = longint'($signed(item.feature_5));
      feat[6] = longint'($signed(item.feature_6));
      feat[7] = longint'($signed(item.feature_7));
      acc = 0;
      for (int i = 0; i < FEATURE_COUNT; i++) begin
         acc += longint'(weights[i]) * feat[i];
      end
      score = clamp_word((acc >>> 8) + longint'(bias));
      y = item.label_positive ? 64'sd1 : -64'sd1;
      met = 1'b0;
      if (item.operation == OP_TRAIN) begin
         lr = longint'(rate);
         decay_rate = lr * longint'(decay_strength);
         met = ((y * score) >= longint'(Q_ONE));
         for (int i = 0; i < FEATURE_COUNT; i++) begin
            w = longint'(weights[i]);
            nw = w - ((decay_rate * w) >>> 32);
            if (!met) begin
               nw += (y * lr * feat[i]) >>> 8;
            end
            weights[i] = 32'(clamp_word(nw));
         end
         if (!met) begin
            bias = 32'(clamp_word(longint'(bias) + y * lr));
         end
      end
      result.class_positive = (score >= 0);
      result.score = 32'(score);
      result.margin_met = met;
   endtask

   task automatic compare_result(input rsp_type got);
      rsp_type want;
      if (score_queue.size() == 0) begin
         errors++;
         $error("result transfer with no expected result: score %0d", $signed(got.score));
      end else begin
         want = score_queue.pop_front();
         if (got.class_positive !== want.class_positive) begin
            errors++;
            $error("class_positive mismatch: expected %0d actual %0d",
                   want.class_positive, got.class_positive);
         end
         if (got.score !== want.score) begin
            errors++;
            $error("score mismatch: expected %0d actual %0d",
                   $signed(want.score), $signed(got.score));
         end
         if (got.margin_met !== want.margin_met) begin
            errors++;
            $error("margin_met mismatch: expected %0d actual %0d",
                   want.margin_met, got.margin_met);
         end
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < FEATURE_COUNT; i++) begin
            weights[i] = '0;
         end
         bias = '0;
         rate = LEARNING_RATE_RESET;
         decay_strength = REGULARIZATION_RESET;
         score_queue.delete();
      end else begin
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_LEARNING_RATE: begin
                  rate = csr_data;
               end
               CSR_REGULARIZATION: begin
                  decay_strength = csr_data;
               end
               default: begin
               end
            endcase
         end
         if (rsp_valid && !rsp_stall) begin
            compare_result(rsp_data);
         end
         if (req_valid && !req_stall) begin
            score_and_update(req_data, predicted);
            score_queue.push_back(predicted);
         end
      end
      mismatch_count <= errors;
      pending_count <= score_queue.size();
   end

endmodule

### bench/tb.sv
`timescale 1ns / 100ps
// testbench top for the svm trainer: clock, reset, stimulus, flow control and verdict
module tb;
   import lsvm_pkg::*;

   localparam int ITEM_LATENCY = FEATURE_COUNT + 5;
   localparam int CYCLE_LIMIT = 400000;
   localparam int PHASE_ITEMS = 175;
   localparam int HOLD_CYCLES = 300;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_SPARE_LOW = 2'd2;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_SPARE_HIGH = 2'd3;

   typedef enum int {
      FEAT_WIDE,
      FEAT_NARROW,
      FEAT_EDGE
   } feature_style;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   req_type req_data = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   rsp_type rsp_data;
   logic csr_valid = 1'b0;
   logic csr_ready;
   logic [CSR_INDEX_WIDTH-1:0] csr_index = '0;
   logic [CSR_DATA_WIDTH-1:0] csr_data = '0;

   int mismatch_count;
   int pending_count;
   int cycle_count = 0;
   int sender_idle_pct = 34;
   int receiver_idle_pct = 34;
   logic hold_go = 1'b0;
   logic hold_used = 1'b0;
   int hold_left = 0;

   linear_svm_sgd_trainer DUT (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data)
   );

   svm_result_checker result_check (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_data       (req_data),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_data       (rsp_data),
      .csr_valid      (csr_valid),
      .csr_ready      (csr_ready),
      .csr_index      (csr_index),
      .csr_data       (csr_data),
      .mismatch_count (mismatch_count),
      .pending_count  (pending_count)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("TEST FAILED");
         $finish;
      end
   end

   // result side: random stall, plus one long hold-off on request
   always @(posedge clock) begin
      if (hold_go && !hold_used) begin
         hold_used <= 1'b1;
         hold_left <= HOLD_CYCLES;
         rsp_stall <= 1'b1;
      end else if (hold_left != 0) begin
         hold_left <= hold_left - 1;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= ($urandom_range(99) < receiver_idle_pct);
      end
   end

   function automatic logic [FEATURE_WIDTH-1:0] pick_feature(input feature_style style);
      case (style)
         FEAT_WIDE: begin
            return 16'($urandom);
         end
         FEAT_NARROW: begin
            return 16'($urandom_range(2047) - 1024);
         end
         default: begin
            case ($urandom_range(4))
               0: return 16'h7fff;
               1: return 16'h8000;
               2: return 16'h0000;
               3: return 16'hffff;
               default: return 16'h0001;
            endcase
         end
      endcase
   endfunction

   function automatic req_type random_item(input feature_style style, input int train_pct);
      req_type item;
      int s;
      item.operation = ($urandom_range(99) < train_pct) ? OP_TRAIN : OP_PREDICT;
      item.feature_0 = pick_feature(style);
      item.feature_1 = pick_feature(style);
      item.feature_2 = pick_feature(style);
      item.feature_3 = pick_feature(style);
      item.feature_4 = pick_feature(style);
      item.feature_5 = pick_feature(style);
      item.feature_6 = pick_feature(style);
      item.feature_7 = pick_feature(style);
      item.label_positive = 1'($urandom_range(1));
      // separable labels so the margin is reached once the weights have learned
      if (style == FEAT_NARROW && $urandom_range(3) != 0) begin
         s = $signed(item.feature_0) - $signed(item.feature_1) + $signed(item.feature_2)
             + $signed(item.feature_5) - $signed(item.feature_6);
         item.label_positive = (s >= 0);
      end
      return item;
   endfunction

   function automatic req_type uniform_item(input logic op, input logic label,
                                            input logic [FEATURE_WIDTH-1:0] value);
      req_type item;
      item.operation = op;
      item.label_positive = label;
      item.feature_0 = value;
      item.feature_1 = value;
      item.feature_2 = value;
      item.feature_3 = value;
      item.feature_4 = value;
      item.feature_5 = value;
      item.feature_6 = value;
      item.feature_7 = value;
      return item;
   endfunction

   task automatic send_item(input req_type item);
      while ($urandom_range(99) < sender_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data <= item;
      @(posedge clock);
      while (req_stall) begin
         @(posedge clock);
      end
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_count != 0) begin
         @(posedge clock);
      end
      repeat (ITEM_LATENCY) @(posedge clock);
   endtask

   task automatic write_reg(input logic [CSR_INDEX_WIDTH-1:0] index,
                            input logic [CSR_DATA_WIDTH-1:0] value);
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_data <= value;
      @(posedge clock);
      while (!csr_ready) begin
         @(posedge clock);
      end
   endtask

   task automatic configure(input logic [CSR_DATA_WIDTH-1:0] rate,
                            input logic [CSR_DATA_WIDTH-1:0] decay);
      write_reg(CSR_LEARNING_RATE, rate);
      write_reg(CSR_REGULARIZATION, decay);
      // unmapped indexes must leave both rates alone
      write_reg(CSR_SPARE_LOW, 16'($urandom));
      write_reg(CSR_SPARE_HIGH, 16'($urandom));
      csr_valid <= 1'b0;
   endtask

   task automatic run_directed();
      req_type item;
      send_item(uniform_item(OP_PREDICT, 1'b0, 16'h0000));
      send_item(uniform_item(OP_TRAIN, 1'b1, 16'h7fff));
      send_item(uniform_item(OP_TRAIN, 1'b0, 16'h8000));
      send_item(uniform_item(OP_PREDICT, 1'b0, 16'h7fff));
      send_item(uniform_item(OP_PREDICT, 1'b0, 16'h8000));
      send_item(uniform_item(OP_PREDICT, 1'b1, 16'hffff));
      item = uniform_item(OP_TRAIN, 1'b1, 16'h0000);
      item.feature_0 = 16'h7fff;
      send_item(item);
      item = uniform_item(OP_TRAIN, 1'b0, 16'h0000);
      item.feature_7 = 16'h8000;
      send_item(item);
      send_item(uniform_item(OP_PREDICT, 1'b1, 16'h0001));
      drain();
      configure(16'hffff, 16'h0000);
      send_item(uniform_item(OP_TRAIN, 1'b1, 16'h7fff));
      send_item(uniform_item(OP_PREDICT, 1'b0, 16'h7fff));
      send_item(uniform_item(OP_PREDICT, 1'b1, 16'h8000));
      send_item(uniform_item(OP_TRAIN, 1'b1, 16'h7fff));
      send_item(uniform_item(OP_TRAIN, 1'b0, 16'h7fff));
      item = uniform_item(OP_PREDICT, 1'b0, 16'h7fff);
      item.feature_1 = 16'h8000;
      item.feature_3 = 16'h8000;
      item.feature_5 = 16'h8000;
      item.feature_7 = 16'h8000;
      send_item(item);
      drain();
      configure(16'hffff, 16'hffff);
      send_item(uniform_item(OP_TRAIN, 1'b1, 16'h7fff));
      send_item(uniform_item(OP_TRAIN, 1'b0, 16'h8000));
      send_item(uniform_item(OP_PREDICT, 1'b0, 16'h7fff));
      drain();
      configure(16'h0000, 16'h0000);
      send_item(uniform_item(OP_TRAIN, 1'b1, 16'h0000));
      send_item(random_item(FEAT_EDGE, 50));
      drain();
   endtask

   task automatic run_phase(input logic [CSR_DATA_WIDTH-1:0] rate,
                            input logic [CSR_DATA_WIDTH-1:0] decay,
                            input int idle_pct, input logic with_hold);
      int style_pick;
      feature_style style;
      configure(rate, decay);
      sender_idle_pct = idle_pct;
      receiver_idle_pct <= idle_pct;
      for (int n = 0; n < PHASE_ITEMS; n++) begin
         if (with_hold && n == 40) begin
            hold_go <= 1'b1;
         end
         style_pick = $urandom_range(9);
         if (style_pick < 5) begin
            style = FEAT_NARROW;
         end else if (style_pick < 8) begin
            style = FEAT_WIDE;
         end else begin
            style = FEAT_EDGE;
         end
         send_item(random_item(style, 60));
      end
      drain();
   endtask

   initial begin
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      run_directed();
      run_phase(LEARNING_RATE_RESET, REGULARIZATION_RESET, 34, 1'b0);
      run_phase(16'hffff, 16'h0000, 34, 1'b1);
      run_phase(16'h0000, 16'hffff, 0, 1'b0);
      run_phase(16'hffff, 16'hffff, 34, 1'b0);
      run_phase(16'h0000, 16'h0000, 34, 1'b0);
      run_phase(16'($urandom), 16'($urandom), 34, 1'b0);
      run_phase(16'd1310, 16'd655, 34, 1'b0);
      run_phase(16'($urandom_range(4000)), 16'($urandom), 34, 1'b0);
      repeat (2 * ITEM_LATENCY) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule
